>>> design/rpf_pkg.sv
`default_nettype none

package rpf_pkg;

    localparam int ROW_BYTES_DEF   = 4096;
    localparam int FIELD_BYTES_DEF = 8;

    localparam int OFF_W   = 12;
    localparam int LEN_W   = 4;
    localparam int TYPE_W  = 3;
    localparam int REL_W   = 3;
    localparam int CONST_W = 64;
    localparam int FIELD_MAX = 8;

    // APB: eight registers on 8-byte strides, 64-bit data
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int REG_LSB = 3;
    localparam int REG_W   = 3;

    typedef enum logic [REG_W-1:0] {
        REG_COMPARE_KIND = 3'd0,
        REG_DATA_TYPE    = 3'd1,
        REG_RELATION     = 3'd2,
        REG_LEFT_OFFSET  = 3'd3,
        REG_LEFT_LENGTH  = 3'd4,
        REG_RIGHT_OFFSET = 3'd5,
        REG_RIGHT_LENGTH = 3'd6,
        REG_CONSTANT     = 3'd7
    } t_reg;

    typedef enum logic [TYPE_W-1:0] {
        DT_KEY  = 3'd0,
        DT_CHAR = 3'd1,
        DT_DATE = 3'd2,
        DT_UINT = 3'd3,
        DT_SINT = 3'd4
    } t_dtype;

    typedef enum logic [REL_W-1:0] {
        REL_LT = 3'd0,
        REL_LE = 3'd1,
        REL_EQ = 3'd2,
        REL_GE = 3'd3,
        REL_GT = 3'd4
    } t_rel;

    localparam logic [TYPE_W-1:0] TYPE_RESET = DT_KEY;
    localparam logic [REL_W-1:0]  REL_RESET  = REL_EQ;

    typedef struct packed {
        logic               column;
        logic [TYPE_W-1:0]  data_type;
        logic [REL_W-1:0]   relation;
        logic [OFF_W-1:0]   left_offset;
        logic [LEN_W-1:0]   left_length;
        logic [OFF_W-1:0]   right_offset;
        logic [LEN_W-1:0]   right_length;
        logic [CONST_W-1:0] constant_value;
    } t_cfg;

    // captured fields of one finished row, byte k of a field at [k]
    typedef struct packed {
        logic                      valid;
        logic                      fault;
        logic [FIELD_MAX-1:0][7:0] left;
        logic [FIELD_MAX-1:0][7:0] right;
    } t_snap;

    // zero counts as one, anything above the field storage is clamped
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n,
                                                 input logic [LEN_W-1:0] max_len);
        logic [LEN_W-1:0] r;
        if (n == '0) begin
            r = LEN_W'(1);
        end else if (n > max_len) begin
            r = max_len;
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/row_field_predicate_filter.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ------------------------------
// row in    input      i_in_valid / o_in_ready  i_row_byte[7:0], i_row_last
// result    output     o_out_valid / i_out_ready o_match, o_fault
// config    APB        psel/penable/pready      paddr[5:3] selects, pwdata[63:0]
//
// One row byte word is taken every cycle while o_in_ready is high.
// After its last byte is taken, the result word for a row passes through these stages:
// snapshot register, compare stage (bytewise order, 8x57 signed multiply), result register.
// Each stage moves when the next one is empty or moving, so stalls at the output
// propagate back to o_in_ready; with i_out_ready held high the input never stalls.
// Reset is synchronous, active low, and clears the byte position and all valid flags.

module row_field_predicate_filter
    import rpf_pkg::*;
#(
    parameter int ROW_BYTES   = ROW_BYTES_DEF,
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [7:0]        i_row_byte,
    input  wire logic              i_row_last,

    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_match,
    output logic                   o_fault,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic               r_column;
    logic [TYPE_W-1:0]  r_data_type;
    logic [REL_W-1:0]   r_relation;
    logic [OFF_W-1:0]   r_left_offset;
    logic [LEN_W-1:0]   r_left_length;
    logic [OFF_W-1:0]   r_right_offset;
    logic [LEN_W-1:0]   r_right_length;
    logic [CONST_W-1:0] r_constant;

    t_cfg  w_cfg;
    t_snap w_snap;
    t_reg  w_sel;
    logic  w_wr;
    logic  w_take;

    assign pready = 1'b1;
    assign w_sel  = t_reg'(paddr[REG_LSB +: REG_W]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column       <= 1'b0;
            r_data_type    <= TYPE_RESET;
            r_relation     <= REL_RESET;
            r_left_offset  <= '0;
            r_left_length  <= LEN_W'(1);
            r_right_offset <= '0;
            r_right_length <= LEN_W'(1);
            r_constant     <= '0;
        end else if (w_wr) begin
            unique case (w_sel)
                REG_COMPARE_KIND: r_column       <= pwdata[0];
                REG_DATA_TYPE:    r_data_type    <= pwdata[TYPE_W-1:0];
                REG_RELATION:     r_relation     <= pwdata[REL_W-1:0];
                REG_LEFT_OFFSET:  r_left_offset  <= pwdata[OFF_W-1:0];
                REG_LEFT_LENGTH:  r_left_length  <= pwdata[LEN_W-1:0];
                REG_RIGHT_OFFSET: r_right_offset <= pwdata[OFF_W-1:0];
                REG_RIGHT_LENGTH: r_right_length <= pwdata[LEN_W-1:0];
                REG_CONSTANT:     r_constant     <= pwdata[CONST_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_COMPARE_KIND: prdata = DATA_W'(r_column);
            REG_DATA_TYPE:    prdata = DATA_W'(r_data_type);
            REG_RELATION:     prdata = DATA_W'(r_relation);
            REG_LEFT_OFFSET:  prdata = DATA_W'(r_left_offset);
            REG_LEFT_LENGTH:  prdata = DATA_W'(r_left_length);
            REG_RIGHT_OFFSET: prdata = DATA_W'(r_right_offset);
            REG_RIGHT_LENGTH: prdata = DATA_W'(r_right_length);
            REG_CONSTANT:     prdata = DATA_W'(r_constant);
            default:          prdata = '0;
        endcase
    end

    assign w_cfg.column         = r_column;
    assign w_cfg.data_type      = r_data_type;
    assign w_cfg.relation       = r_relation;
    assign w_cfg.left_offset    = r_left_offset;
    assign w_cfg.left_length    = r_left_length;
    assign w_cfg.right_offset   = r_right_offset;
    assign w_cfg.right_length   = r_right_length;
    assign w_cfg.constant_value = r_constant;

    rpf_capture #(
        .ROW_BYTES   (ROW_BYTES),
        .FIELD_BYTES (FIELD_BYTES)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_row_byte),
        .i_last  (i_row_last),
        .o_snap  (w_snap),
        .i_take  (w_take)
    );

    rpf_compare #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_compare (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_snap  (w_snap),
        .o_take  (w_take),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_match (o_match),
        .o_fault (o_fault)
    );

endmodule

`default_nettype wire

>>> design/rpf_capture.sv
`default_nettype none

module rpf_capture
    import rpf_pkg::*;
#(
    parameter int ROW_BYTES   = ROW_BYTES_DEF,
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_snap           o_snap,
    input  wire logic       i_take
);

    localparam int POS_W = $clog2(ROW_BYTES + 1);
    localparam int SUM_W = OFF_W + 1;
    localparam int CMP_W = (POS_W > SUM_W) ? POS_W : SUM_W;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [FIELD_BYTES-1:0][7:0] r_left, n_left;
    logic [FIELD_BYTES-1:0][7:0] r_right, n_right;

    logic                      r_snap_valid;
    logic                      r_snap_fault;
    logic [FIELD_MAX-1:0][7:0] r_snap_left;
    logic [FIELD_MAX-1:0][7:0] r_snap_right;

    logic             w_accept;
    logic             w_not_full;
    logic [LEN_W-1:0] w_ll, w_rl;
    logic [CMP_W-1:0] w_pos, w_lo, w_ro, w_ldiff, w_rdiff, w_row_len;
    logic             w_lhit, w_rhit, w_fault;

    assign o_ready  = !r_snap_valid || i_take;
    assign w_accept = i_valid && o_ready;

    assign w_ll = eff_len(i_cfg.left_length, LEN_W'(FIELD_BYTES));
    assign w_rl = eff_len(i_cfg.right_length, LEN_W'(FIELD_BYTES));

    assign w_not_full = r_pos < POS_W'(ROW_BYTES);
    assign w_pos   = CMP_W'(r_pos);
    assign w_lo    = CMP_W'(i_cfg.left_offset);
    assign w_ro    = CMP_W'(i_cfg.right_offset);
    assign w_ldiff = w_pos - w_lo;
    assign w_rdiff = w_pos - w_ro;
    assign w_lhit  = w_not_full && (w_pos >= w_lo) && (w_ldiff < CMP_W'(w_ll));
    assign w_rhit  = w_not_full && (w_pos >= w_ro) && (w_rdiff < CMP_W'(w_rl));

    // bytes past the row limit are dropped and the row counts as full length
    assign w_row_len = w_not_full ? (w_pos + CMP_W'(1)) : CMP_W'(ROW_BYTES);
    assign w_fault   = ((w_lo + CMP_W'(w_ll)) > w_row_len) ||
                       (i_cfg.column && ((w_ro + CMP_W'(w_rl)) > w_row_len));

    always_comb begin
        n_pos   = r_pos;
        n_left  = r_left;
        n_right = r_right;
        if (w_accept) begin
            for (int k = 0; k < FIELD_BYTES; k++) begin
                if (w_lhit && (w_ldiff == CMP_W'(k))) begin
                    n_left[k] = i_byte;
                end
                if (w_rhit && (w_rdiff == CMP_W'(k))) begin
                    n_right[k] = i_byte;
                end
            end
            if (w_not_full) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (i_last) begin
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (o_ready) begin
                r_snap_valid <= w_accept && i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        if (w_accept && i_last) begin
            r_snap_fault <= w_fault;
            r_snap_left  <= (8 * FIELD_MAX)'(n_left);
            r_snap_right <= (8 * FIELD_MAX)'(n_right);
        end
    end

    assign o_snap.valid = r_snap_valid;
    assign o_snap.fault = r_snap_fault;
    assign o_snap.left  = r_snap_left;
    assign o_snap.right = r_snap_right;

endmodule

`default_nettype wire

>>> design/rpf_compare.sv
`default_nettype none

module rpf_compare
    import rpf_pkg::*;
#(
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_snap i_snap,
    output logic       o_take,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic       o_match,
    output logic       o_fault
);

    // stage 2: bytewise and unsigned orders, signed products
    logic               r_s2_valid;
    logic               r_s2_fault;
    logic               r_b_lt, r_b_gt, n_b_lt, n_b_gt;
    logic               r_u_lt, r_u_gt;
    logic signed [63:0] r_p_l, r_p_r, n_p_l, n_p_r;

    // stage 3: result word
    logic r_out_valid, r_out_match, r_out_fault;

    logic w_out_load, w_s2_load;

    logic [LEN_W-1:0]          w_ll, w_rl, w_m;
    logic [FIELD_MAX-1:0][7:0] w_rbytes;
    logic [63:0]               w_ua, w_ub;

    assign w_out_load = !r_out_valid || i_ready;
    assign w_s2_load  = !r_s2_valid || w_out_load;
    assign o_take     = w_s2_load;

    // constant mode: the constant takes the left field's length
    assign w_ll     = eff_len(i_cfg.left_length, LEN_W'(FIELD_BYTES));
    assign w_rl     = i_cfg.column ? eff_len(i_cfg.right_length, LEN_W'(FIELD_BYTES)) : w_ll;
    assign w_rbytes = i_cfg.column ? i_snap.right : i_cfg.constant_value;
    assign w_m      = (w_ll < w_rl) ? w_ll : w_rl;

    always_comb begin
        logic        done;
        logic        stop_nul;
        logic [55:0] mag_l, mag_r;
        logic signed [7:0]  s_l, s_r;
        logic signed [56:0] m_l, m_r;

        done     = 1'b0;
        stop_nul = (i_cfg.data_type != DT_KEY);
        n_b_lt   = 1'b0;
        n_b_gt   = 1'b0;
        for (int i = 0; i < FIELD_MAX; i++) begin
            if (!done && (LEN_W'(i) < w_m)) begin
                if (i_snap.left[i] != w_rbytes[i]) begin
                    done   = 1'b1;
                    n_b_lt = i_snap.left[i] < w_rbytes[i];
                    n_b_gt = i_snap.left[i] > w_rbytes[i];
                end else if (stop_nul && (i_snap.left[i] == 8'h00)) begin
                    done = 1'b1;
                end
            end
        end
        // tie on the common part: the shorter column is smaller
        if (!n_b_lt && !n_b_gt && i_cfg.column) begin
            n_b_lt = w_ll < w_rl;
            n_b_gt = w_ll > w_rl;
        end

        w_ua  = '0;
        w_ub  = '0;
        mag_l = '0;
        mag_r = '0;
        for (int i = 0; i < FIELD_MAX; i++) begin
            if (LEN_W'(i) < w_ll) begin
                w_ua[8*i +: 8] = i_snap.left[i];
            end
            if (LEN_W'(i) < w_rl) begin
                w_ub[8*i +: 8] = w_rbytes[i];
            end
        end
        for (int i = 1; i < FIELD_MAX; i++) begin
            if (LEN_W'(i) < w_ll) begin
                mag_l[8*(i-1) +: 8] = i_snap.left[i];
            end
            if (LEN_W'(i) < w_rl) begin
                mag_r[8*(i-1) +: 8] = w_rbytes[i];
            end
        end
        s_l   = signed'(i_snap.left[0]);
        s_r   = signed'(w_rbytes[0]);
        m_l   = signed'({1'b0, mag_l});
        m_r   = signed'({1'b0, mag_r});
        n_p_l = s_l * m_l;
        n_p_r = s_r * m_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_load) begin
            r_s2_valid <= i_snap.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load && i_snap.valid) begin
            r_s2_fault <= i_snap.fault;
            r_b_lt     <= n_b_lt;
            r_b_gt     <= n_b_gt;
            r_u_lt     <= w_ua < w_ub;
            r_u_gt     <= w_ua > w_ub;
            r_p_l      <= n_p_l;
            r_p_r      <= n_p_r;
        end
    end

    logic w_lt, w_gt, w_known, w_holds;

    always_comb begin
        w_lt    = 1'b0;
        w_gt    = 1'b0;
        w_known = 1'b1;
        unique case (i_cfg.data_type)
            DT_KEY, DT_CHAR, DT_DATE: begin
                w_lt = r_b_lt;
                w_gt = r_b_gt;
            end
            DT_UINT: begin
                w_lt = r_u_lt;
                w_gt = r_u_gt;
            end
            DT_SINT: begin
                w_lt = r_p_l < r_p_r;
                w_gt = r_p_l > r_p_r;
            end
            default: w_known = 1'b0;
        endcase

        w_holds = 1'b0;
        unique case (i_cfg.relation)
            REL_LT:  w_holds = w_lt;
            REL_LE:  w_holds = !w_gt;
            REL_EQ:  w_holds = !w_lt && !w_gt;
            REL_GE:  w_holds = !w_lt;
            REL_GT:  w_holds = w_gt;
            default: w_holds = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s2_valid) begin
            r_out_fault <= r_s2_fault;
            r_out_match <= !r_s2_fault && w_known && w_holds;
        end
    end

    assign o_valid = r_out_valid;
    assign o_match = r_out_match;
    assign o_fault = r_out_fault;

endmodule

`default_nettype wire

>>> test/tb_row_field_predicate_filter.sv
`timescale 1ns / 100ps

module tb_row_field_predicate_filter;
    import rpf_pkg::*;

    localparam int RANDOM_WORDS = 1930;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int ORDER_NONE   = 2;
    localparam logic [TYPE_W-1:0] DT_UNUSED  = TYPE_W'(int'(DT_SINT) + 3);
    localparam logic [REL_W-1:0]  REL_UNUSED = REL_W'(int'(REL_GT) + 1);
    localparam logic [OFF_W-1:0]  OFF_MAX    = '1;

    typedef logic [FIELD_MAX-1:0][7:0] field_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } row_word_t;

    typedef struct packed {
        logic match;
        logic fault;
    } verdict_t;

    typedef struct {
        bit          keep_cfg;
        t_cfg        cfg;
        int          n;
        logic [63:0] bytes;
        bit          pinned;
        verdict_t    want;
    } dir_case_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_row_byte = '0;
    logic              i_row_last = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_match;
    logic              o_fault;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    row_word_t   row_words[$];
    verdict_t    verdicts[$];
    dir_case_t   dir_tab[$];
    row_word_t   next_word;
    verdict_t    seen_want;

    // predictor copy of the registers and capture state
    t_cfg        flt;
    field_t      left_cap;
    field_t      right_cap;
    int unsigned row_pos;

    bit          pin_on;
    verdict_t    pin_want;

    int send_gap_pct = 13;
    int recv_gap_pct = 75;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int words_queued = 0;
    int words_taken = 0;
    int results_seen = 0;
    int settings_used = 0;
    int fails = 0;
    int idle_cycles = 0;

    row_field_predicate_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_row_byte  (i_row_byte),
        .i_row_last  (i_row_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_match     (o_match),
        .o_fault     (o_fault),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned fld_len(logic [LEN_W-1:0] n);
        if (n == '0) return 1;
        if (n > FIELD_MAX) return FIELD_MAX;
        return int'(n);
    endfunction

    function automatic longint unsigned le_mag(field_t f, int from, int n);
        longint unsigned v;
        int i;
        v = 0;
        for (i = n - 1; i >= from; i--) v = (v << 8) | 64'(f[i]);
        return v;
    endfunction

    // first byte is a signed multiplier on the magnitude of the rest
    function automatic longint sint_val(field_t f, int n);
        longint s;
        s = $signed(f[0]);
        return s * longint'(le_mag(f, 1, n));
    endfunction

    function automatic int field_order(field_t a, int unsigned la, field_t b, int unsigned lb,
                                       logic [TYPE_W-1:0] dtype, bit column);
        int c;
        int i;
        int unsigned m;
        bit stop;
        longint unsigned ua, ub;
        longint sa, sb;
        c = 0;
        stop = 0;
        m = (la < lb) ? la : lb;
        case (dtype)
            DT_KEY, DT_CHAR, DT_DATE: begin
                for (i = 0; i < int'(m) && c == 0 && !stop; i++) begin
                    if (a[i] != b[i]) c = (a[i] < b[i]) ? -1 : 1;
                    else if (dtype != DT_KEY && a[i] == 8'h00) stop = 1;
                end
                // equal prefix: shorter field sorts first
                if (c == 0 && column) c = (la < lb) ? -1 : ((la > lb) ? 1 : 0);
            end
            DT_UINT: begin
                ua = le_mag(a, 0, la);
                ub = le_mag(b, 0, lb);
                c = (ua < ub) ? -1 : ((ua > ub) ? 1 : 0);
            end
            DT_SINT: begin
                sa = sint_val(a, la);
                sb = sint_val(b, lb);
                c = (sa < sb) ? -1 : ((sa > sb) ? 1 : 0);
            end
            default: c = ORDER_NONE;
        endcase
        return c;
    endfunction

    function automatic logic rel_holds(logic [REL_W-1:0] rel, int c);
        case (rel)
            REL_LT:  return c < 0;
            REL_LE:  return c <= 0;
            REL_EQ:  return c == 0;
            REL_GE:  return c >= 0;
            REL_GT:  return c > 0;
            default: return 1'b0;
        endcase
    endfunction

    task automatic take_row_byte(logic [7:0] b, logic last);
        int unsigned ll, rl, lo, ro, row_len;
        int c;
        verdict_t v;
        ll = fld_len(flt.left_length);
        rl = fld_len(flt.right_length);
        lo = flt.left_offset;
        ro = flt.right_offset;
        if (row_pos < ROW_BYTES_DEF) begin
            if (row_pos >= lo && row_pos - lo < ll) left_cap[row_pos - lo] = b;
            if (row_pos >= ro && row_pos - ro < rl) right_cap[row_pos - ro] = b;
            row_pos++;
            row_len = row_pos;
        end else begin
            row_len = ROW_BYTES_DEF;
        end
        if (last) begin
            row_pos = 0;
            v.fault = (lo + ll > row_len) || (flt.column && ro + rl > row_len);
            v.match = 1'b0;
            if (!v.fault) begin
                if (flt.column)
                    c = field_order(left_cap, ll, right_cap, rl, flt.data_type, 1'b1);
                else
                    c = field_order(left_cap, ll, flt.constant_value, ll, flt.data_type, 1'b0);
                if (c != ORDER_NONE) v.match = rel_holds(flt.relation, c);
            end
            if (pin_on) begin
                verdicts.insert(verdicts.size(), pin_want);
                pin_on = 0;
            end else begin
                verdicts.insert(verdicts.size(), v);
            end
        end
    endtask

    function automatic t_cfg mk_cfg(logic column, logic [TYPE_W-1:0] dtype,
                                    logic [REL_W-1:0] rel, logic [OFF_W-1:0] loff,
                                    logic [LEN_W-1:0] llen, logic [OFF_W-1:0] roff,
                                    logic [LEN_W-1:0] rlen, logic [CONST_W-1:0] cval);
        t_cfg c;
        c.column         = column;
        c.data_type      = dtype;
        c.relation       = rel;
        c.left_offset    = loff;
        c.left_length    = llen;
        c.right_offset   = roff;
        c.right_length   = rlen;
        c.constant_value = cval;
        return c;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0, 1:    return 8'h00;
            2:       return 8'hFF;
            3:       return 8'h80;
            4:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        if ($urandom_range(9) != 0) return LEN_W'($urandom_range(1, FIELD_MAX));
        if ($urandom_range(1) == 0) return '0;
        return LEN_W'($urandom_range(FIELD_MAX + 1, (1 << LEN_W) - 1));
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        int i;
        c.column = 1'($urandom_range(1));
        if ($urandom_range(19) == 0)
            c.data_type = TYPE_W'(int'(DT_SINT) + $urandom_range(1, 3));
        else
            c.data_type = TYPE_W'($urandom_range(int'(DT_SINT)));
        if ($urandom_range(19) == 0)
            c.relation = REL_W'(int'(REL_GT) + $urandom_range(1, 3));
        else
            c.relation = REL_W'($urandom_range(int'(REL_GT)));
        c.left_length  = rand_len();
        c.right_length = rand_len();
        // far offsets cannot fit a short row, so those rows fault
        c.left_offset  = ($urandom_range(9) == 0) ? OFF_W'($urandom) : OFF_W'($urandom_range(20));
        c.right_offset = ($urandom_range(9) == 0) ? OFF_W'($urandom) : OFF_W'($urandom_range(20));
        for (i = 0; i < FIELD_MAX; i++) c.constant_value[8*i +: 8] = rand_byte();
        return c;
    endfunction

    task automatic apb_write(t_reg idx, logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << REG_LSB;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COMPARE_KIND: flt.column         = val[0];
            REG_DATA_TYPE:    flt.data_type      = val[TYPE_W-1:0];
            REG_RELATION:     flt.relation       = val[REL_W-1:0];
            REG_LEFT_OFFSET:  flt.left_offset    = val[OFF_W-1:0];
            REG_LEFT_LENGTH:  flt.left_length    = val[LEN_W-1:0];
            REG_RIGHT_OFFSET: flt.right_offset   = val[OFF_W-1:0];
            REG_RIGHT_LENGTH: flt.right_length   = val[LEN_W-1:0];
            REG_CONSTANT:     flt.constant_value = val[CONST_W-1:0];
        endcase
    endtask

    task automatic load_filter(t_cfg c);
        apb_write(REG_COMPARE_KIND, DATA_W'(c.column));
        apb_write(REG_DATA_TYPE, DATA_W'(c.data_type));
        apb_write(REG_RELATION, DATA_W'(c.relation));
        apb_write(REG_LEFT_OFFSET, DATA_W'(c.left_offset));
        apb_write(REG_LEFT_LENGTH, DATA_W'(c.left_length));
        apb_write(REG_RIGHT_OFFSET, DATA_W'(c.right_offset));
        apb_write(REG_RIGHT_LENGTH, DATA_W'(c.right_length));
        apb_write(REG_CONSTANT, DATA_W'(c.constant_value));
        settings_used++;
    endtask

    task automatic queue_word(logic [7:0] d, logic last);
        row_word_t w;
        w.data = d;
        w.last = last;
        row_words.insert(row_words.size(), w);
        words_queued++;
    endtask

    task automatic add_case(bit keep, t_cfg c, int n, logic [63:0] bytes,
                            bit pinned, logic m, logic f);
        dir_case_t e;
        e.keep_cfg   = keep;
        e.cfg        = c;
        e.n          = n;
        e.bytes      = bytes;
        e.pinned     = pinned;
        e.want.match = m;
        e.want.fault = f;
        dir_tab.insert(dir_tab.size(), e);
    endtask

    // mostly rows that hold every field, often with equal operands to hit ties
    task automatic queue_random_row(output int n);
        logic [7:0] rb [0:63];
        int unsigned ll, rl, lo, ro, need;
        int k;
        ll = fld_len(flt.left_length);
        rl = fld_len(flt.right_length);
        lo = flt.left_offset;
        ro = flt.right_offset;
        need = lo + ll;
        if (flt.column && ro + rl > need) need = ro + rl;
        if (need > 48) n = $urandom_range(1, 48);
        else if (need > 1 && $urandom_range(9) == 0) n = $urandom_range(1, need - 1);
        else n = need + $urandom_range(0, 6);
        for (k = 0; k < n; k++) rb[k] = rand_byte();
        if ($urandom_range(9) < 4) begin
            for (k = 0; k < int'(ll); k++) begin
                if (flt.column) begin
                    if (k < int'(rl) && lo + k < n && ro + k < n) rb[lo + k] = rb[ro + k];
                end else if (lo + k < n) begin
                    rb[lo + k] = flt.constant_value[8*k +: 8];
                end
            end
            if ($urandom_range(1) == 1) begin
                k = $urandom_range(ll - 1);
                if (lo + k < n) rb[lo + k] = rb[lo + k] + (($urandom_range(1) == 1) ? 8'h01 : 8'hFF);
            end
        end
        for (k = 0; k < n; k++) queue_word(rb[k], k == n - 1);
    endtask

    task automatic wait_idle();
        while (words_taken != words_queued || verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_in_valid || o_in_ready) begin
            if (i_rst_n && row_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_word = row_words.pop_front();
                i_in_valid <= 1'b1;
                i_row_byte <= next_word.data;
                i_row_last <= next_word.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // result check, input capture and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (verdicts.size() == 0) begin
                    $error("result word with none expected: match=%0b fault=%0b",
                           o_match, o_fault);
                    fails++;
                end else begin
                    seen_want = verdicts.pop_front();
                    if (o_match !== seen_want.match) begin
                        $error("match: expected %0b, got %0b", seen_want.match, o_match);
                        fails++;
                    end
                    if (o_fault !== seen_want.fault) begin
                        $error("fault: expected %0b, got %0b", seen_want.fault, o_fault);
                        fails++;
                    end
                    results_seen++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                take_row_byte(i_row_byte, i_row_last);
                words_taken++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int j, n, rand_words;
        bit held;
        flt = mk_cfg(1'b0, TYPE_RESET, REL_RESET, '0, LEN_W'(1), '0, LEN_W'(1), '0);
        left_cap = '0;
        right_cap = '0;
        row_pos = 0;
        pin_on = 0;
        held = 0;
        rand_words = 0;

        // byte 0 of a row sits in bits 7:0 of the row column
        add_case(1, '0, 1, 64'h00, 1, 1'b1, 1'b0);
        add_case(0, mk_cfg(1'b0, DT_KEY, REL_EQ, 0, 1, 0, 1, '1), 1, 64'hFF, 1, 1'b1, 1'b0);
        add_case(0, mk_cfg(1'b0, DT_KEY, REL_LT, 1, 2, 0, 1, 64'h0301), 3, 64'h020100,
                 0, 1'b0, 1'b0);
        add_case(0, mk_cfg(1'b0, DT_KEY, REL_EQ, 2, 2, 0, 1, '0), 2, 64'hBBAA, 1, 1'b0, 1'b1);
        add_case(0, mk_cfg(1'b1, DT_CHAR, REL_LE, 0, 3, 3, 2, '0), 5, 64'h00_41_7F_00_41,
                 0, 1'b0, 1'b0);
        add_case(0, mk_cfg(1'b1, DT_DATE, REL_GT, 0, 1, 1, 1, '0), 2, 64'h7F80, 0, 1'b0, 1'b0);
        add_case(0, mk_cfg(1'b0, DT_UINT, REL_GE, 0, 0, 0, 1, 64'h80), 1, 64'h80,
                 0, 1'b0, 1'b0);
        add_case(0, mk_cfg(1'b0, DT_SINT, REL_LT, 0, 15, 0, 1, 64'h01), 8, '1, 0, 1'b0, 1'b0);
        add_case(0, mk_cfg(1'b0, DT_UNUSED, REL_EQ, 0, 1, 0, 1, '0), 1, 64'h00, 1, 1'b0, 1'b0);
        add_case(0, mk_cfg(1'b0, DT_KEY, REL_UNUSED, 0, 1, 0, 1, '0), 1, 64'h00, 1, 1'b0, 1'b0);
        add_case(0, mk_cfg(1'b1, DT_KEY, REL_EQ, 0, 1, OFF_MAX, 8, '0), 1, 64'h00,
                 1, 1'b0, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            if (!dir_tab[k].keep_cfg) load_filter(dir_tab[k].cfg);
            pin_on = dir_tab[k].pinned;
            pin_want = dir_tab[k].want;
            for (j = 0; j < dir_tab[k].n; j++)
                queue_word(dir_tab[k].bytes[8*j +: 8], j == dir_tab[k].n - 1);
            wait_idle();
        end

        while (rand_words < RANDOM_WORDS) begin
            if (rand_words >= 2 * RANDOM_WORDS / 3) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end else if (rand_words >= RANDOM_WORDS / 3) begin
                send_gap_pct = 75;
                recv_gap_pct = 13;
            end
            load_filter(random_cfg());
            repeat ($urandom_range(4, 12)) begin
                queue_random_row(n);
                rand_words += n;
            end
            // stall the output once while rows keep coming
            if (!held) begin
                held = 1;
                hold_asked++;
            end
            wait_idle();
        end

        $display("Streamed %0d row words under %0d filter settings, %0d results checked.",
                 words_taken, settings_used, results_seen);
        $display("Covered all types and relations, unused codes, faults and length clamping.");
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
